// ===== src/timed_event_scheduler_top_defines.svh =====
// Assertion macros for the timed event scheduler.
// Included by timed_event_scheduler_top; needs nothing else.
`ifndef TIMED_EVENT_SCHEDULER_TOP_DEFINES_SVH
`define TIMED_EVENT_SCHEDULER_TOP_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define TES_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/tes_pkg.sv =====
// Package for the timed event scheduler: beat types, codes and sequencer states.
// Used by timed_event_scheduler_top; depends on nothing.
`default_nettype none
package tes_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCHED,
      ST_CANCEL,
      ST_ADV,
      ST_SCAN,
      ST_PICK,
      ST_CLEAR,
      ST_RESP
   } state_type;

   localparam logic [1:0] FUNC_SCHEDULE = 2'd0;
   localparam logic [1:0] FUNC_CANCEL   = 2'd1;
   localparam logic [1:0] FUNC_ADVANCE  = 2'd2;
   localparam logic [1:0] FUNC_RESET    = 2'd3;

   localparam logic [2:0] KIND_SCHEDULED  = 3'd0;
   localparam logic [2:0] KIND_CANCEL_HIT = 3'd1;
   localparam logic [2:0] KIND_CANCEL_MISS = 3'd2;
   localparam logic [2:0] KIND_FIRED      = 3'd3;
   localparam logic [2:0] KIND_NONE_DUE   = 3'd4;
   localparam logic [2:0] KIND_FULL       = 3'd5;
   localparam logic [2:0] KIND_RESET_DONE = 3'd6;

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] amount;
      logic [31:0] event_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] event_id_res;
      logic [63:0] lateness;
      logic [63:0] now;
      logic [4:0]  pending;
      logic        last;
   } rsp_type;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[64] ? '1 : sum[63:0];
   endfunction

   function automatic rsp_type make_rsp(input logic [2:0] kind, input logic [31:0] id,
                                        input logic [63:0] late, input logic [63:0] now,
                                        input logic [4:0] pend, input logic last);
      rsp_type r;
      r.kind         = kind;
      r.event_id_res = id;
      r.lateness     = late;
      r.now          = now;
      r.pending      = pend;
      r.last         = last;
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/tes_slot_mem.sv =====
// Slot store of the scheduler: due times and identifiers, one write and one read port.
// Read data is registered. Depends on nothing.
`default_nettype none
module tes_slot_mem #(
   parameter int DEPTH    = 16,
   parameter int ID_WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [63:0]              wr_due,
   input  wire logic [ID_WIDTH-1:0]      wr_id,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [63:0]                   rd_due,
   output logic [ID_WIDTH-1:0]           rd_id
);

   logic [63:0]         due_mem_ff [DEPTH];
   logic [ID_WIDTH-1:0] id_mem_ff  [DEPTH];
   logic [63:0]         rd_due_ff;
   logic [ID_WIDTH-1:0] rd_id_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         due_mem_ff[wr_addr] <= wr_due;
         id_mem_ff[wr_addr]  <= wr_id;
      end
      rd_due_ff <= due_mem_ff[rd_addr];
      rd_id_ff  <= id_mem_ff[rd_addr];
   end

   assign rd_due = rd_due_ff;
   assign rd_id  = rd_id_ff;

endmodule
`default_nettype wire

// ===== src/timed_event_scheduler_top.sv =====
// Timed event scheduler: a table of pending events, a tick counter and an id counter.
// Uses tes_pkg, tes_slot_mem and timed_event_scheduler_top_defines.svh.
//
// The request channel (req_valid, req_ready, req_data) carries one command per beat:
// schedule, cancel, advance time or reset. The response channel (rsp_valid, rsp_ready,
// rsp_data) returns one beat per result; the final beat of a command has last set.
// One command is worked on at a time and req_ready is high only while the block idles.
// A schedule or a reset goes through ST_SCHED or ST_CLEAR to ST_RESP. A cancel walks
// the slot store one slot per cycle from slot 0 up to a hit or the last slot. An advance
// makes one pass over the store per fired event plus a closing pass that finds none due.
// The walks are paced by the single read port of the slot store and the one comparator
// that judges one slot per cycle.
// A result waits in an output register while rsp_ready is low; the sequencer stalls
// until that register is free. Reset empties the table, zeroes the tick counter and
// sets the next id to one. The slot store is not cleared; entries of free slots are ignored.
`default_nettype none
`include "timed_event_scheduler_top_defines.svh"
module timed_event_scheduler_top #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_WIDTH    = 32
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire tes_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output tes_pkg::rsp_type     rsp_data
);

   localparam int AW   = $clog2(QUEUE_DEPTH);
   localparam int CW   = $clog2(QUEUE_DEPTH + 1);
   localparam int CMPW = (ID_WIDTH > 32) ? ID_WIDTH : 32;
   localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

   tes_pkg::state_type state_ff, state_in;
   tes_pkg::req_type   req_ff, req_in;
   logic [63:0]             tick_ff, tick_in;
   logic [ID_WIDTH-1:0]     next_id_ff, next_id_in;
   logic [QUEUE_DEPTH-1:0]  valid_ff, valid_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [AW-1:0]           scan_addr_ff, scan_addr_in;
   logic                    scan_issue_ff, scan_issue_in;
   logic [AW-1:0]           cmp_slot_ff, cmp_slot_in;
   logic                    cmp_vld_ff, cmp_vld_in;
   logic                    best_found_ff, best_found_in;
   logic [63:0]             best_due_ff, best_due_in;
   logic [ID_WIDTH-1:0]     best_id_ff, best_id_in;
   logic [AW-1:0]           best_slot_ff, best_slot_in;
   logic                    held_ff, held_in;
   tes_pkg::rsp_type        held_rsp_ff, held_rsp_in;
   tes_pkg::rsp_type        rec_ff, rec_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   tes_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic                req_fire;
   logic                rsp_load;
   logic                scanning;
   logic                free_found;
   logic [AW-1:0]       free_slot;
   logic [ID_WIDTH-1:0] id_after;
   logic                wr_en;
   logic [63:0]         mem_due;
   logic [ID_WIDTH-1:0] mem_id;
   logic                cand;
   logic                better;
   logic                hit;
   logic [CW-1:0]       count_dec;
   logic [CW-1:0]       count_inc;

   tes_slot_mem #(
      .DEPTH    (QUEUE_DEPTH),
      .ID_WIDTH (ID_WIDTH)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (free_slot),
      .wr_due  (tes_pkg::sat_add(tick_ff, req_ff.amount)),
      .wr_id   (next_id_ff),
      .rd_addr (scan_addr_ff),
      .rd_due  (mem_due),
      .rd_id   (mem_id)
   );

   // Lowest-numbered free slot.
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_slot  = AW'(i);
         end
      end
   end

   always_comb begin
      id_after  = next_id_ff + ID_WIDTH'(1);
      if (id_after == '0) begin
         id_after = ID_WIDTH'(1);
      end
      count_dec = count_ff - CW'(1);
      count_inc = count_ff + CW'(1);
      cand      = valid_ff[cmp_slot_ff] && (mem_due <= tick_ff);
      better    = !best_found_ff || (mem_due < best_due_ff) ||
                  ((mem_due == best_due_ff) && (mem_id < best_id_ff));
      hit       = valid_ff[cmp_slot_ff] && (CMPW'(mem_id) == CMPW'(req_ff.event_id));
   end

   // Handshake and sequencer outputs.
   always_comb begin
      req_ready = (state_ff == tes_pkg::ST_IDLE);
      req_fire  = req_valid && req_ready;
      rsp_load  = (state_ff == tes_pkg::ST_RESP) && (!rsp_valid_ff || rsp_ready);
      scanning  = (state_ff == tes_pkg::ST_SCAN) || (state_ff == tes_pkg::ST_CANCEL);
      wr_en     = (state_ff == tes_pkg::ST_SCHED) && free_found;
      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_data_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tes_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_data.func)
                  tes_pkg::FUNC_SCHEDULE: state_in = tes_pkg::ST_SCHED;
                  tes_pkg::FUNC_CANCEL:   state_in = tes_pkg::ST_CANCEL;
                  tes_pkg::FUNC_ADVANCE:  state_in = tes_pkg::ST_ADV;
                  default:                state_in = tes_pkg::ST_CLEAR;
               endcase
            end
         end
         tes_pkg::ST_SCHED: state_in = tes_pkg::ST_RESP;
         tes_pkg::ST_CLEAR: state_in = tes_pkg::ST_RESP;
         tes_pkg::ST_ADV:   state_in = tes_pkg::ST_SCAN;
         tes_pkg::ST_CANCEL: begin
            if (cmp_vld_ff && (hit || cmp_slot_ff == LAST_SLOT)) begin
               state_in = tes_pkg::ST_RESP;
            end
         end
         tes_pkg::ST_SCAN: begin
            if (cmp_vld_ff && cmp_slot_ff == LAST_SLOT) begin
               state_in = tes_pkg::ST_PICK;
            end
         end
         tes_pkg::ST_PICK: begin
            if (best_found_ff && !held_ff) begin
               state_in = tes_pkg::ST_SCAN;
            end else begin
               state_in = tes_pkg::ST_RESP;
            end
         end
         tes_pkg::ST_RESP: begin
            if (rsp_load) begin
               state_in = rec_ff.last ? tes_pkg::ST_IDLE : tes_pkg::ST_SCAN;
            end
         end
         default: state_in = tes_pkg::ST_IDLE;
      endcase
   end

   // Datapath next values.
   always_comb begin
      req_in        = req_ff;
      tick_in       = tick_ff;
      next_id_in    = next_id_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      scan_addr_in  = scan_addr_ff;
      scan_issue_in = scan_issue_ff;
      cmp_slot_in   = scan_addr_ff;
      cmp_vld_in    = scanning && scan_issue_ff;
      best_found_in = best_found_ff;
      best_due_in   = best_due_ff;
      best_id_in    = best_id_ff;
      best_slot_in  = best_slot_ff;
      held_in       = held_ff;
      held_rsp_in   = held_rsp_ff;
      rec_in        = rec_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      if (scanning && scan_issue_ff) begin
         scan_addr_in = scan_addr_ff + AW'(1);
         if (scan_addr_ff == LAST_SLOT) begin
            scan_issue_in = 1'b0;
         end
      end

      case (state_ff)
         tes_pkg::ST_IDLE: begin
            if (req_fire) begin
               req_in        = req_data;
               scan_addr_in  = '0;
               scan_issue_in = 1'b1;
               best_found_in = 1'b0;
            end
         end
         tes_pkg::ST_SCHED: begin
            if (free_found) begin
               valid_in[free_slot] = 1'b1;
               count_in   = count_inc;
               next_id_in = id_after;
               rec_in = tes_pkg::make_rsp(tes_pkg::KIND_SCHEDULED, 32'(next_id_ff), '0,
                                          tick_ff, 5'(count_inc), 1'b1);
            end else begin
               rec_in = tes_pkg::make_rsp(tes_pkg::KIND_FULL, '0, '0, tick_ff,
                                          5'(count_ff), 1'b1);
            end
         end
         tes_pkg::ST_CANCEL: begin
            if (cmp_vld_ff) begin
               if (hit) begin
                  valid_in[cmp_slot_ff] = 1'b0;
                  count_in = count_dec;
                  rec_in = tes_pkg::make_rsp(tes_pkg::KIND_CANCEL_HIT, '0, '0, tick_ff,
                                             5'(count_dec), 1'b1);
               end else if (cmp_slot_ff == LAST_SLOT) begin
                  rec_in = tes_pkg::make_rsp(tes_pkg::KIND_CANCEL_MISS, '0, '0, tick_ff,
                                             5'(count_ff), 1'b1);
               end
            end
         end
         tes_pkg::ST_ADV: begin
            tick_in       = tes_pkg::sat_add(tick_ff, req_ff.amount);
            held_in       = 1'b0;
            scan_addr_in  = '0;
            scan_issue_in = 1'b1;
            best_found_in = 1'b0;
         end
         tes_pkg::ST_SCAN: begin
            if (cmp_vld_ff && cand && better) begin
               best_found_in = 1'b1;
               best_due_in   = mem_due;
               best_id_in    = mem_id;
               best_slot_in  = cmp_slot_ff;
            end
         end
         tes_pkg::ST_PICK: begin
            // A fired event is held back one pass so its beat can carry the right last flag.
            scan_addr_in  = '0;
            scan_issue_in = 1'b1;
            best_found_in = 1'b0;
            if (best_found_ff) begin
               valid_in[best_slot_ff] = 1'b0;
               count_in    = count_dec;
               held_in     = 1'b1;
               held_rsp_in = tes_pkg::make_rsp(tes_pkg::KIND_FIRED, 32'(best_id_ff),
                                               tick_ff - best_due_ff, tick_ff,
                                               5'(count_dec), 1'b0);
               rec_in      = held_rsp_ff;
            end else if (held_ff) begin
               rec_in      = held_rsp_ff;
               rec_in.last = 1'b1;
            end else begin
               rec_in = tes_pkg::make_rsp(tes_pkg::KIND_NONE_DUE, '0, '0, tick_ff,
                                          5'(count_ff), 1'b1);
            end
         end
         tes_pkg::ST_CLEAR: begin
            tick_in    = '0;
            next_id_in = ID_WIDTH'(1);
            valid_in   = '0;
            count_in   = '0;
            rec_in = tes_pkg::make_rsp(tes_pkg::KIND_RESET_DONE, '0, '0, '0, '0, 1'b1);
         end
         tes_pkg::ST_RESP: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rec_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tes_pkg::ST_IDLE;
         tick_ff       <= '0;
         next_id_ff    <= ID_WIDTH'(1);
         valid_ff      <= '0;
         count_ff      <= '0;
         scan_issue_ff <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         best_found_ff <= 1'b0;
         held_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tick_ff       <= tick_in;
         next_id_ff    <= next_id_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         scan_issue_ff <= scan_issue_in;
         cmp_vld_ff    <= cmp_vld_in;
         best_found_ff <= best_found_in;
         held_ff       <= held_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      scan_addr_ff <= scan_addr_in;
      cmp_slot_ff  <= cmp_slot_in;
      best_due_ff  <= best_due_in;
      best_id_ff   <= best_id_in;
      best_slot_ff <= best_slot_in;
      held_rsp_ff  <= held_rsp_in;
      rec_ff       <= rec_in;
      rsp_data_ff  <= rsp_data_in;
   end

   `TES_ASSERT_ALWAYS(a_count_matches_valid, clock, reset, count_ff == CW'($countones(valid_ff)), "pending count disagrees with slot valid bits")
   `TES_ASSERT_ALWAYS(a_next_id_nonzero, clock, reset, next_id_ff != '0, "identifier counter reached zero")
   `TES_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, state_ff != tes_pkg::ST_IDLE, "sequencer idle after accepting a beat")

endmodule
`default_nettype wire

// ===== dv/tes_event_checker.sv =====
// Checker for the timed event scheduler: mirrors the event table to predict each response
// beat and compares accepted beats field by field. Depends on tes_pkg for beat types and codes.
module tes_event_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire tes_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire tes_pkg::rsp_type rsp_data,
   output int                    errors,
   output int                    waiting
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS      = 16;
   localparam int FIFO_DEPTH = 64;

   logic [63:0] now_ticks;
   logic [31:0] next_tag;
   logic        live [SLOTS];
   logic [63:0] due_at [SLOTS];
   logic [31:0] tag_of [SLOTS];
   tes_pkg::rsp_type awaited_rsps [FIFO_DEPTH];
   int          head = 0;
   int          tail = 0;
   int          mism = 0;

   function automatic logic [63:0] add_clamped(input logic [63:0] a, input logic [63:0] b);
      return (b > ~a) ? '1 : a + b;
   endfunction

   function automatic logic [4:0] live_count();
      logic [4:0] n;
      n = '0;
      for (int i = 0; i < SLOTS; i++) n += live[i];
      return n;
   endfunction

   // Builds a beat from the current tick count and table occupancy.
   function automatic tes_pkg::rsp_type beat(input logic [2:0] kind, input logic [31:0] id,
                                             input logic [63:0] late, input logic fin);
      tes_pkg::rsp_type b;
      b.kind         = kind;
      b.event_id_res = id;
      b.lateness     = late;
      b.now          = now_ticks;
      b.pending      = live_count();
      b.last         = fin;
      return b;
   endfunction

   // Appends a predicted beat to the ring of beats still owed by the block.
   task automatic post_beat(input tes_pkg::rsp_type b);
      awaited_rsps[tail % FIFO_DEPTH] = b;
      tail++;
   endtask

   task automatic clear_table();
      now_ticks = '0;
      next_tag  = 32'd1;
      for (int i = 0; i < SLOTS; i++) live[i] = 1'b0;
   endtask

   task automatic apply_command(input tes_pkg::req_type c);
      int      slot;
      int      best;
      logic [31:0] id;
      tes_pkg::rsp_type held;
      bit      have_held;
      slot = -1;
      have_held = 0;
      case (c.func)
         tes_pkg::FUNC_SCHEDULE: begin
            for (int i = 0; i < SLOTS; i++) if (slot < 0 && !live[i]) slot = i;
            if (slot < 0) begin
               post_beat(beat(tes_pkg::KIND_FULL, '0, '0, 1'b1));
            end else begin
               id = next_tag;
               live[slot]   = 1'b1;
               due_at[slot] = add_clamped(now_ticks, c.amount);
               tag_of[slot] = id;
               next_tag = id + 32'd1;
               if (next_tag == '0) next_tag = 32'd1;
               post_beat(beat(tes_pkg::KIND_SCHEDULED, id, '0, 1'b1));
            end
         end
         tes_pkg::FUNC_CANCEL: begin
            for (int i = 0; i < SLOTS; i++)
               if (slot < 0 && live[i] && tag_of[i] == c.event_id) slot = i;
            if (slot >= 0) begin
               live[slot] = 1'b0;
               post_beat(beat(tes_pkg::KIND_CANCEL_HIT, '0, '0, 1'b1));
            end else begin
               post_beat(beat(tes_pkg::KIND_CANCEL_MISS, '0, '0, 1'b1));
            end
         end
         tes_pkg::FUNC_ADVANCE: begin
            now_ticks = add_clamped(now_ticks, c.amount);
            // Fire earliest due first; equal due goes by lower id, then lower slot.
            do begin
               best = -1;
               for (int i = 0; i < SLOTS; i++) begin
                  if (live[i] && due_at[i] <= now_ticks) begin
                     if (best < 0 || due_at[i] < due_at[best] ||
                         (due_at[i] == due_at[best] && tag_of[i] < tag_of[best]))
                        best = i;
                  end
               end
               if (best >= 0) begin
                  live[best] = 1'b0;
                  if (have_held) post_beat(held);
                  held = beat(tes_pkg::KIND_FIRED, tag_of[best], now_ticks - due_at[best],
                              1'b0);
                  have_held = 1;
               end
            end while (best >= 0);
            if (have_held) begin
               held.last = 1'b1;
               post_beat(held);
            end else begin
               post_beat(beat(tes_pkg::KIND_NONE_DUE, '0, '0, 1'b1));
            end
         end
         default: begin
            clear_table();
            post_beat(beat(tes_pkg::KIND_RESET_DONE, '0, '0, 1'b1));
         end
      endcase
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         mism++;
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   task automatic check_beat(input tes_pkg::rsp_type got);
      tes_pkg::rsp_type want;
      if (tail == head) begin
         mism++;
         $display("%0t: unexpected response beat, expected none, actual %p", $time, got);
      end else begin
         want = awaited_rsps[head % FIFO_DEPTH];
         head++;
         compare_field("kind", want.kind, got.kind);
         compare_field("event_id_res", want.event_id_res, got.event_id_res);
         compare_field("lateness", want.lateness, got.lateness);
         compare_field("now", want.now, got.now);
         compare_field("pending", want.pending, got.pending);
         compare_field("last", want.last, got.last);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_table();
         head = 0;
         tail = 0;
      end else begin
         // A beat of an older command may leave in the same cycle a new one enters.
         if (rsp_valid && rsp_ready) check_beat(rsp_data);
         if (req_valid && req_ready) apply_command(req_data);
      end
      errors  <= mism;
      waiting <= tail - head;
   end

endmodule

// ===== dv/tb_timed_event_scheduler_top.sv =====
// Testbench top for the timed event scheduler: clock, reset, command stimulus and verdict.
// Depends on tes_pkg, timed_event_scheduler_top and tes_event_checker.
module tb_timed_event_scheduler_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             rsp_ready = 1'b0;
   tes_pkg::req_type req_data  = '0;
   logic             req_ready;
   logic             rsp_valid;
   tes_pkg::rsp_type rsp_data;
   int               errors;
   int               waiting;
   bit               steady = 0;
   int unsigned      sched_sent = 0;

   always #4 clock = ~clock;

   timed_event_scheduler_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   tes_event_checker events_chk (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .errors    (errors),
      .waiting   (waiting)
   );

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 31);
   end

   // Presents one command beat and holds it until the block takes it.
   task automatic send(input logic [1:0] f, input logic [63:0] amt, input logic [31:0] id);
      tes_pkg::req_type c;
      c.func     = f;
      c.amount   = amt;
      c.event_id = id;
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 31) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= c;
      do @(posedge clock); while (!req_ready);
      if (f == tes_pkg::FUNC_SCHEDULE) sched_sent++;
      if (f == tes_pkg::FUNC_RESET) sched_sent = 0;
   endtask

   initial begin
      int          r;
      int unsigned back;
      logic [63:0] amt;
      logic [31:0] id;
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      send(tes_pkg::FUNC_ADVANCE, '0, '0);
      send(tes_pkg::FUNC_CANCEL, '0, '0);
      send(tes_pkg::FUNC_SCHEDULE, '1, '0);
      // Tick count reaches its maximum here, and the far event fires on time.
      send(tes_pkg::FUNC_ADVANCE, '1, '1);
      send(tes_pkg::FUNC_SCHEDULE, 64'd3, '0);
      send(tes_pkg::FUNC_ADVANCE, '0, '0);
      send(tes_pkg::FUNC_RESET, '1, '1);
      // Sixteen fill the table with tied due times; the seventeenth finds it full.
      for (int i = 0; i < 17; i++) send(tes_pkg::FUNC_SCHEDULE, 64'(i % 3), $urandom);
      send(tes_pkg::FUNC_CANCEL, '0, '1);
      send(tes_pkg::FUNC_CANCEL, '0, 32'd5);
      send(tes_pkg::FUNC_ADVANCE, 64'd1, '0);
      send(tes_pkg::FUNC_ADVANCE, 64'd1, '0);

      for (int n = 0; n < 400; n++) begin
         steady = (n >= 150 && n < 250);
         r = $urandom_range(0, 99);
         if (r < 40) begin
            r = $urandom_range(0, 99);
            if (r < 90) amt = 64'($urandom_range(0, 40));
            else if (r < 95) amt = {$urandom, $urandom};
            else amt = '1 - 64'($urandom_range(0, 3));
            send(tes_pkg::FUNC_SCHEDULE, amt, $urandom);
         end else if (r < 60) begin
            r = $urandom_range(0, 99);
            if (r < 15 || sched_sent == 0) begin
               id = (r < 15) ? $urandom : '0;
            end else begin
               back = (sched_sent > 24) ? 24 : sched_sent - 1;
               id = sched_sent - $urandom_range(0, back);
            end
            send(tes_pkg::FUNC_CANCEL, {$urandom, $urandom}, id);
         end else if (r < 97) begin
            amt = ($urandom_range(0, 99) < 92) ? 64'($urandom_range(0, 24))
                                                : {$urandom, $urandom};
            send(tes_pkg::FUNC_ADVANCE, amt, $urandom);
         end else begin
            send(tes_pkg::FUNC_RESET, {$urandom, $urandom}, $urandom);
         end
      end
      steady = 0;
      @(negedge clock) req_valid <= 1'b0;

      while (waiting != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
